// ----- sv/double_ended_queue_with_search_unit_macros.svh -----
// Assertion macros for the double-ended queue with search unit.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DQS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DQS_ASSERT_SAME(lbl, ante, cons, msg)
`define DQS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/dqs_pkg.sv -----
// Package with types, codes and sizes for the double-ended queue with search unit.
package dqs_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_REAR   = 3'd3;
	localparam logic [2:0] ACT_SEARCH     = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped;
		logic               found;
		logic               is_empty;
		logic [CNT_W-1:0]   fill;
	} result_t;

	typedef struct packed {
		logic               wr;
		logic               rd;
		logic [IDX_W-1:0]   off;
		logic signed [31:0] wdata;
		logic               head_inc;
		logic               head_dec;
		logic               cnt_inc;
		logic               cnt_dec;
	} ring_cmd_t;

endpackage

// ----- sv/dqs_ring.sv -----
// Ring store of the queue: slot memory, head index and fill count.
module dqs_ring import dqs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  ring_cmd_t           rcmd,
	output logic [CNT_W-1:0]    count,
	output logic signed [31:0]  rd_data
);

	logic signed [31:0] slots_q [DEPTH];
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [31:0] rd_data_q;
	logic [IDX_W:0]     sum;
	logic [IDX_W-1:0]   addr;

	// Physical slot is head plus offset, wrapped once around the ring.
	assign sum  = {1'b0, head_q} + {1'b0, rcmd.off};
	assign addr = (sum >= (IDX_W+1)'(DEPTH)) ? IDX_W'(sum - (IDX_W+1)'(DEPTH))
	                                         : sum[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (rcmd.wr) begin
			slots_q[addr] <= rcmd.wdata;
		end
		if (rcmd.rd) begin
			rd_data_q <= slots_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (rcmd.head_dec) begin
				head_q <= (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
			end else if (rcmd.head_inc) begin
				head_q <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (rcmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (rcmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign count   = count_q;
	assign rd_data = rd_data_q;

endmodule

// ----- sv/dqs_ctrl.sv -----
// Sequencer of the queue: action decode, search walk with a shared comparator, result register.
module dqs_ctrl import dqs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  item_t              cmd,
	output logic               busy,
	input  logic [CNT_W-1:0]   count,
	input  logic signed [31:0] rd_data,
	output ring_cmd_t          rcmd,
	output logic               done,
	output result_t            result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_POPD = 2'd2;
	localparam logic [1:0] S_SRCH = 2'd3;

	logic [1:0]         state_q;
	logic [2:0]         act_q;
	logic signed [31:0] key_q;
	logic [IDX_W-1:0]   idx_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic signed [31:0] popped_q;
	logic               found_q;

	logic               full;
	logic               empty;
	logic               hit;
	logic               last;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   idx_nxt;

	assign full    = (count == CNT_W'(DEPTH));
	assign empty   = (count == '0);
	assign cnt_m1  = count - 1'b1;
	assign idx_nxt = idx_q + 1'b1;
	// The one comparator, reused for each held entry compared during a search.
	assign hit     = (rd_data == key_q);
	assign last    = ((CNT_W'(idx_q) + 1'b1) == count);

	always_comb begin
		rcmd       = '0;
		rcmd.wdata = key_q;
		if (state_q == S_EXEC) begin
			case (act_q)
				ACT_PUSH_FRONT: begin
					if (!full) begin
						rcmd.wr       = 1'b1;
						rcmd.off      = IDX_W'(DEPTH - 1);
						rcmd.head_dec = 1'b1;
						rcmd.cnt_inc  = 1'b1;
					end
				end
				ACT_PUSH_REAR: begin
					if (!full) begin
						rcmd.wr      = 1'b1;
						rcmd.off     = count[IDX_W-1:0];
						rcmd.cnt_inc = 1'b1;
					end
				end
				ACT_POP_FRONT: begin
					if (!empty) begin
						rcmd.rd       = 1'b1;
						rcmd.head_inc = 1'b1;
						rcmd.cnt_dec  = 1'b1;
					end
				end
				ACT_POP_REAR: begin
					if (!empty) begin
						rcmd.rd      = 1'b1;
						rcmd.off     = cnt_m1[IDX_W-1:0];
						rcmd.cnt_dec = 1'b1;
					end
				end
				ACT_SEARCH: begin
					rcmd.rd = !empty;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SRCH && !hit && !last) begin
			rcmd.rd  = 1'b1;
			rcmd.off = idx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						ACT_POP_FRONT, ACT_POP_REAR: begin
							state_q <= empty ? S_IDLE : S_POPD;
							done_q  <= empty;
						end
						ACT_SEARCH: begin
							state_q <= empty ? S_IDLE : S_SRCH;
							done_q  <= empty;
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_POPD: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SRCH: begin
					if (hit || last) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					act_q <= cmd.action;
					key_q <= cmd.value;
				end
			end
			S_EXEC: begin
				idx_q    <= '0;
				popped_q <= '0;
				found_q  <= 1'b0;
				status_q <= ST_DONE;
				if ((act_q == ACT_PUSH_FRONT || act_q == ACT_PUSH_REAR) && full) begin
					status_q <= ST_FULL;
				end
				if ((act_q == ACT_POP_FRONT || act_q == ACT_POP_REAR) && empty) begin
					status_q <= ST_EMPTY;
				end
			end
			S_POPD: begin
				popped_q <= rd_data;
			end
			S_SRCH: begin
				found_q <= hit;
				idx_q   <= idx_nxt;
			end
			default: begin
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign result.status   = status_q;
	assign result.popped   = popped_q;
	assign result.found    = found_q;
	// Count has already taken this action's update when the result shows.
	assign result.is_empty = empty;
	assign result.fill     = count;

endmodule

// ----- sv/double_ended_queue_with_search_unit.sv -----
// Top level of the double-ended queue with search unit.
//
// Channel   Signals                  Beat taken when
// -------   ----------------------   -----------------------------------
// input     start, busy, cmd         rising edge with start high, busy low
// output    done, result             rising edge ending the done cycle
//
// A push passes through the execute state to the done beat, a pop that is not refused
// also through the read state, and a search walks the held entries to a hit or the last one.
// The search length is set by the single comparator, which sees one slot per
// cycle through the registered read port of the slot memory.
// Reset clears the head index, the fill count and the sequencer; slot contents
// are left as they are. The receiver cannot stall: each result shows for one
// cycle with done high, and busy drops in that same cycle.
`include "double_ended_queue_with_search_unit_macros.svh"

module double_ended_queue_with_search_unit import dqs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	// Command from the sequencer to the ring store for the current cycle.
	ring_cmd_t          rcmd;
	// Number of held values, after every update already applied.
	logic [CNT_W-1:0]   count;
	// Slot read data, registered in the cycle after the read is issued.
	logic signed [31:0] rd_data;

	// The sequencer decodes each action and walks the ring for searches.
	dqs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.count   (count),
		.rd_data (rd_data),
		.rcmd    (rcmd),
		.done    (done),
		.result  (result)
	);

	// The ring store maps offsets from the head onto physical slots.
	dqs_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rcmd    (rcmd),
		.count   (count),
		.rd_data (rd_data)
	);

	// The fill count never runs past the ring size.
	`DQS_ASSERT_SAME(a_fill_max, 1'b1, count <= CNT_W'(DEPTH), "fill count exceeds depth")
	// A result only follows a cycle in which the block was working.
	`DQS_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result beat without an item at work")
	// An accepted beat makes the block busy in the next cycle.
	`DQS_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "accepted beat did not start work")
	// A rejected push is only reported when the ring is full.
	`DQS_ASSERT_SAME(a_full_status, done && result.status == ST_FULL,
		result.fill == CNT_W'(DEPTH), "full status with free slots")
	// Popped data is zero whenever the status is not done.
	`DQS_ASSERT_SAME(a_popped_zero, done && result.status != ST_DONE,
		result.popped == '0, "nonzero popped value on a failed action")

endmodule

// ----- dv/dqs_checker.sv -----
// Checker for the double-ended queue with search unit: predicts each result and compares it.
module dqs_checker import dqs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   cmd,
	input  logic    done,
	input  result_t result,
	output int      errors,
	output int      pending
);

	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the ring store, its head and its fill count.
	logic signed [31:0] ring [DEPTH];
	logic [IDX_W-1:0]   front;
	logic [CNT_W-1:0]   held;

	result_t results_due [$];
	result_t due;

	initial errors = 0;

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("%s is %h, predicted %h", name, got, want));
		end
	endtask

	// Applies one command to the shadow deque and returns the result it must produce.
	function automatic result_t apply_command(input item_t it);
		result_t r;
		logic [IDX_W-1:0] pos;
		r = '0;
		r.status = ST_DONE;
		case (it.action)
			ACT_PUSH_FRONT: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					front = front - 1'b1;
					ring[front] = it.value;
					held = held + 1'b1;
				end
			end
			ACT_PUSH_REAR: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = front + held[IDX_W-1:0];
					ring[pos] = it.value;
					held = held + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.popped = ring[front];
					front = front + 1'b1;
					held = held - 1'b1;
				end
			end
			ACT_POP_REAR: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = front + held[IDX_W-1:0] - 1'b1;
					r.popped = ring[pos];
					held = held - 1'b1;
				end
			end
			ACT_SEARCH: begin
				for (int k = 0; k < held; k++) begin
					pos = front + k[IDX_W-1:0];
					if (ring[pos] == it.value) begin
						r.found = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.is_empty = (held == 0);
		r.fill = held;
		return r;
	endfunction

	// The result beat of an earlier command and the command beat of the next one may share
	// an edge; the result is matched first, so the order of the queue is kept.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front = '0;
			held = '0;
			results_due.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					report_error("result beat with no command outstanding");
				end else begin
					due = results_due.pop_front();
					compare_field("status", 32'(result.status), 32'(due.status));
					compare_field("popped", result.popped, due.popped);
					compare_field("found", 32'(result.found), 32'(due.found));
					compare_field("is_empty", 32'(result.is_empty), 32'(due.is_empty));
					compare_field("fill", 32'(result.fill), 32'(due.fill));
				end
			end
			if (start && !busy) begin
				results_due.push_back(apply_command(cmd));
			end
			pending = results_due.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the double-ended queue with search unit: stimulus, clock, reset and verdict.
module tb;

	import dqs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Action codes 5 to 7 have no meaning; the unit must leave its contents alone.
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	// Mixes of actions used in the random part, each kept for a stretch of beats.
	localparam int MIX_FILL    = 0;
	localparam int MIX_DRAIN   = 1;
	localparam int MIX_EVEN    = 2;
	localparam int MIX_SEARCH  = 3;

	localparam int RANDOM_BEATS = 1600;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   cmd;
	logic    busy;
	logic    done;
	result_t result;
	int      errors;
	int      pending;

	// Recently pushed values, so that most searches look for something that may be held.
	logic signed [31:0] recent [8];
	int                 recent_wr;

	// Bookkeeping for the bursty sender.
	int burst_left;

	double_ended_queue_with_search_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	dqs_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Idle cycles between bursts. While start is low the command bus carries
	// garbage, which the unit must not pick up.
	task automatic idle_gap(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= {3'($urandom), 32'($urandom)};
		end
	endtask

	// Drives one command beat and holds it until the unit takes it. A new burst
	// starts with a random length; about a third of the gaps are empty, which
	// gives stretches of back-to-back beats.
	task automatic issue(input logic [2:0] act, input logic signed [31:0] val);
		@(negedge clk);
		start <= 1'b1;
		cmd.action <= act;
		cmd.value <= val;
		do @(posedge clk); while (busy);
		if (act == ACT_PUSH_FRONT || act == ACT_PUSH_REAR) begin
			recent[recent_wr] = val;
			recent_wr = (recent_wr + 1) % 8;
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(20, 1);
			if ($urandom_range(2, 0) != 0) begin
				idle_gap($urandom_range(DEPTH + 4, 1));
			end
		end
	endtask

	// Values lean on the extremes and on a tiny range, so that duplicates and
	// sign edges show up often in searches.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9, 0))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2, 3: return $signed(32'($urandom_range(4, 0))) - 32'sd2;
			default: return $signed($urandom);
		endcase
	endfunction

	// Chooses an action under the current mix; a few percent are spare codes.
	function automatic logic [2:0] pick_action(input int mix);
		int roll;
		int push_pct;
		int pop_pct;
		roll = $urandom_range(99, 0);
		case (mix)
			MIX_FILL:  begin push_pct = 70; pop_pct = 15; end
			MIX_DRAIN: begin push_pct = 15; pop_pct = 70; end
			MIX_EVEN:  begin push_pct = 40; pop_pct = 40; end
			default:   begin push_pct = 30; pop_pct = 25; end
		endcase
		if (roll < 3) begin
			return 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
		end
		roll = $urandom_range(99, 0);
		if (roll < push_pct) begin
			return $urandom_range(1, 0) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
		end
		if (roll < push_pct + pop_pct) begin
			return $urandom_range(1, 0) ? ACT_POP_REAR : ACT_POP_FRONT;
		end
		return ACT_SEARCH;
	endfunction

	initial begin
		logic signed [31:0] corner [4];
		logic signed [31:0] rear_val;
		logic signed [31:0] val;
		logic [2:0]         act;
		int                 mix;

		corner[0] = 32'sh7fff_ffff;
		corner[1] = 32'sh8000_0000;
		corner[2] = 32'sh0000_0000;
		corner[3] = 32'shffff_ffff;
		rear_val = '0;
		recent_wr = 0;
		burst_left = 4;
		foreach (recent[k]) begin
			recent[k] = '0;
		end

		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. On an empty deque: both pops are refused, a search finds
		// nothing, and spare codes report the empty contents.
		issue(ACT_POP_FRONT, 32'sh1234_5678);
		issue(ACT_POP_REAR, 32'shffff_ffff);
		issue(ACT_SEARCH, 32'sh0000_0000);
		issue(ACT_SPARE_FIRST, 32'sh7fff_ffff);
		issue(ACT_SPARE_LAST, 32'sh8000_0000);

		// Fill it up from both ends, starting with the extreme values.
		for (int i = 0; i < DEPTH; i++) begin
			val = (i < 4) ? corner[i] : $signed($urandom);
			if (i[0]) begin
				rear_val = val;
				issue(ACT_PUSH_REAR, val);
			end else begin
				issue(ACT_PUSH_FRONT, val);
			end
		end

		// Full: both pushes are rejected; the search for the rear entry takes
		// the longest walk, the miss walks the whole store.
		issue(ACT_PUSH_FRONT, 32'sh0bad_0001);
		issue(ACT_PUSH_REAR, 32'sh0bad_0002);
		issue(ACT_SEARCH, rear_val);
		issue(ACT_SEARCH, 32'sh5a5a_a5a5);
		issue(ACT_SPARE_FIRST + 3'd1, 32'sh0000_0001);

		// Random part. The mix changes every few dozen beats, so the deque swings
		// between full and empty and spends time at both ends.
		mix = MIX_DRAIN;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 40 == 0) begin
				mix = $urandom_range(MIX_SEARCH, MIX_FILL);
			end
			// Now and then the sender drops start and holds off until every
			// result is back.
			if (n % 300 == 150) begin
				idle_gap(1);
				while (pending != 0) @(negedge clk);
			end
			act = pick_action(mix);
			if (act == ACT_SEARCH && $urandom_range(9, 0) < 7) begin
				val = recent[$urandom_range(7, 0)];
			end else begin
				val = pick_value();
			end
			issue(act, val);
		end

		idle_gap(1);
		while (pending != 0) @(negedge clk);
		// Wait longer than the longest search, to catch a stray result beat.
		repeat (DEPTH + 6) @(negedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// The time limit lies well beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("Timed out with %0d results outstanding", pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
